### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define U8U16_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define U8U16_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### src/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the transcoder controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8u16_pkg;

   localparam int WIN_DEPTH = 4;
   localparam int CNT_W     = $clog2(WIN_DEPTH + 1);

   localparam logic [15:0] REPL_UNIT  = 16'hFFFD;
   localparam logic [15:0] TERM_UNIT  = 16'h0000;
   localparam logic [15:0] HI_SURR    = 16'hD800;
   localparam logic [15:0] LO_SURR    = 16'hDC00;

   localparam logic [20:0] SUPP_BASE  = 21'h10000;
   localparam logic [20:0] MAX_CP     = 21'h10FFFF;
   localparam logic [20:0] MIN_TWO    = 21'h80;
   localparam logic [20:0] MIN_THREE  = 21'h800;
   localparam logic [20:0] SURR_FIRST = 21'hD800;
   localparam logic [20:0] SURR_LAST  = 21'hDFFF;

   // Source of the code unit loaded into the hold stage.
   typedef enum logic [1:0] {
      UNIT_POINT,
      UNIT_LOW,
      UNIT_REPL,
      UNIT_TERM
   } unit_sel_type;

   typedef struct packed {
      logic         append;    // write the accepted byte into the window
      logic         emit;      // load a new unit into the hold stage
      unit_sel_type sel;
      logic         drop_seq;  // drop the bytes of the decoded sequence
      logic         drop_one;  // drop the lead byte only
      logic         flush;     // move the held unit out as the last of the run
   } dp_cmd_type;

   typedef struct packed {
      logic empty;       // window holds no byte
      logic incomplete;  // lead announces more bytes than are held
      logic pair;        // head sequence decodes to a surrogate pair
      logic can_emit;    // hold stage can take a unit this cycle
      logic out_free;    // output register can take a beat this cycle
      logic hold_valid;
   } dp_status_type;

endpackage

### src/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// UTF-8 byte stream in, UTF-16 code units out, with a closing null unit.
// ----------------------------------------------------------------------------
// Input channel (req_): one UTF-8 byte per beat; req_last_byte marks the
// final byte of a string. Output channel (rsp_): one UTF-16 code unit per
// beat. rsp_end_of_run marks the last unit caused by an input byte, and
// rsp_end_of_string marks the null unit that closes each string.
// Bytes collect in a four-byte window until the lead's sequence is whole.
// Malformed input becomes U+FFFD; code points above U+FFFF leave as a
// surrogate pair.
// The block takes one byte at a time. A byte that completes a sequence
// sends its unit through the hold stage and the output register to
// rsp_valid, and each further unit follows it. The final byte of a
// string drains the window and adds the terminator. The decode
// sequencer steps once per unit. Reset empties the window, the hold stage
// and the output register; the block comes out of reset ready. When the
// receiver stalls, the held unit and the sequencer wait, and no byte is
// taken until the run's last unit has moved into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_input_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_end_of_run,
   output logic        rsp_end_of_string
);
   import u8u16_pkg::*;

   // Command and status between sequencer and datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer: accept, decode steps, surrogate low half, terminator.
   u8u16_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .req_ready     (req_ready),
      .cmd           (cmd),
      .status        (status)
   );

   // Window, decoder, hold stage and output register (sets end of run).
   u8u16_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_input_byte    (req_input_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_end_of_run    (rsp_end_of_run),
      .rsp_end_of_string (rsp_end_of_string)
   );

endmodule

### src/u8u16_ctrl.sv
// ----------------------------------------------------------------------------
// u8u16_ctrl
// Sequencer: accepts a byte, then steps the datapath through every sequence
// the window can decode, the end-of-string drain and the terminator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8u16_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last_byte,
   output logic                    req_ready,
   output u8u16_pkg::dp_cmd_type   cmd,
   input  u8u16_pkg::dp_status_type status
);
   import u8u16_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOW,
      ST_TERM
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      req_ready_ff;

   assign req_ready = req_ready_ff;

   always_comb begin
      cmd      = '0;
      cmd.sel  = UNIT_POINT;
      state_in = state_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.append = 1'b1;
               last_in    = req_last_byte;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.empty && last_ff) begin
               state_in = ST_TERM;
            end else if (status.empty || (status.incomplete && !last_ff)) begin
               // nothing more to decode: close the run
               if (!status.hold_valid) begin
                  state_in = ST_IDLE;
               end else if (status.out_free) begin
                  cmd.flush = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else if (status.incomplete) begin
               // string ended inside a sequence: replace the lead, rescan
               if (status.can_emit) begin
                  cmd.emit     = 1'b1;
                  cmd.sel      = UNIT_REPL;
                  cmd.drop_one = 1'b1;
               end
            end else if (status.can_emit) begin
               cmd.emit     = 1'b1;
               cmd.sel      = UNIT_POINT;
               cmd.drop_seq = 1'b1;
               if (status.pair) begin
                  state_in = ST_LOW;
               end
            end
         end
         ST_LOW: begin
            if (status.can_emit) begin
               cmd.emit = 1'b1;
               cmd.sel  = UNIT_LOW;
               state_in = ST_DECODE;
            end
         end
         ST_TERM: begin
            if (status.can_emit) begin
               cmd.emit = 1'b1;
               cmd.sel  = UNIT_TERM;
               last_in  = 1'b0;
               state_in = ST_DECODE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

   `U8U16_ASSERT(a_idle_hold_empty, clock, reset, (state_ff == ST_IDLE) |-> !status.hold_valid, "hold stage not drained at end of run")
   `U8U16_ASSERT(a_term_clears_last, clock, reset, (state_ff == ST_TERM) && status.can_emit |=> !last_ff, "end-of-string mark kept after terminator")
   `U8U16_ASSERT(a_ready_only_idle, clock, reset, req_ready_ff |-> (state_ff == ST_IDLE), "input ready outside idle")

endmodule

### src/u8u16_datapath.sv
// ----------------------------------------------------------------------------
// u8u16_datapath
// Byte window, head-sequence decoder, hold stage and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8u16_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                req_input_byte,
   input  u8u16_pkg::dp_cmd_type     cmd,
   output u8u16_pkg::dp_status_type  status,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [15:0]               rsp_code_unit,
   output logic                      rsp_end_of_run,
   output logic                      rsp_end_of_string
);
   import u8u16_pkg::*;

   logic [7:0]       win_ff [WIN_DEPTH];
   logic [7:0]       win_in [WIN_DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [CNT_W-1:0] need, seq_k, k_drop;
   logic             seq_ok, range_ok, good, pair;
   logic [20:0]      cp, cp_off;
   logic [15:0]      unit_point, lo_point, unit_new;
   logic [2:0]       cont_ok;

   logic             hold_valid_ff;
   logic [15:0]      hold_unit_ff;
   logic             hold_eos_ff;
   logic [15:0]      lo_ff;

   logic             rsp_valid_ff, rsp_eor_ff, rsp_eos_ff;
   logic [15:0]      rsp_unit_ff;
   logic             out_free, push;

   // Decode the sequence at the head of the window.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cont_ok[i] = (win_ff[i+1][7:6] == 2'b10);
      end
      need     = CNT_W'(1);
      seq_k    = CNT_W'(1);
      seq_ok   = 1'b1;
      range_ok = 1'b1;
      cp       = {13'd0, win_ff[0]};
      priority if (!win_ff[0][7]) begin
         need = CNT_W'(1);
      end else if (win_ff[0][7:5] == 3'b110) begin
         need     = CNT_W'(2);
         cp       = {10'd0, win_ff[0][4:0], win_ff[1][5:0]};
         range_ok = (cp >= MIN_TWO);
         if (!cont_ok[0]) begin
            seq_ok = 1'b0;
         end else begin
            seq_k = CNT_W'(2);
         end
      end else if (win_ff[0][7:4] == 4'b1110) begin
         need     = CNT_W'(3);
         cp       = {5'd0, win_ff[0][3:0], win_ff[1][5:0], win_ff[2][5:0]};
         range_ok = (cp >= MIN_THREE) && !((cp >= SURR_FIRST) && (cp <= SURR_LAST));
         priority if (!cont_ok[0]) begin
            seq_ok = 1'b0;
         end else if (!cont_ok[1]) begin
            seq_ok = 1'b0;
            seq_k  = CNT_W'(2);
         end else begin
            seq_k = CNT_W'(3);
         end
      end else if (win_ff[0][7:3] == 5'b11110) begin
         need     = CNT_W'(4);
         cp       = {win_ff[0][2:0], win_ff[1][5:0], win_ff[2][5:0], win_ff[3][5:0]};
         range_ok = (cp >= SUPP_BASE) && (cp <= MAX_CP);
         priority if (!cont_ok[0]) begin
            seq_ok = 1'b0;
         end else if (!cont_ok[1]) begin
            seq_ok = 1'b0;
            seq_k  = CNT_W'(2);
         end else if (!cont_ok[2]) begin
            seq_ok = 1'b0;
            seq_k  = CNT_W'(3);
         end else begin
            seq_k = CNT_W'(4);
         end
      end else begin
         seq_ok = 1'b0;
      end
      good       = seq_ok && range_ok;
      pair       = good && (cp[20:16] != 5'd0);
      cp_off     = cp - SUPP_BASE;
      lo_point   = LO_SURR | {6'd0, cp_off[9:0]};
      priority if (!good) begin
         unit_point = REPL_UNIT;
      end else if (pair) begin
         unit_point = HI_SURR | {6'd0, cp_off[19:10]};
      end else begin
         unit_point = cp[15:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign push     = hold_valid_ff && (cmd.emit || cmd.flush);

   always_comb begin
      status            = '0;
      status.empty      = (cnt_ff == '0);
      status.incomplete = (cnt_ff < need);
      status.pair       = pair;
      status.out_free   = out_free;
      status.can_emit   = !hold_valid_ff || out_free;
      status.hold_valid = hold_valid_ff;
   end

   // Window update: append at the fill point, or drop from the front.
   assign k_drop = cmd.drop_one ? CNT_W'(1) : seq_k;

   always_comb begin
      logic [CNT_W:0] src;
      src = '0;
      for (int j = 0; j < WIN_DEPTH; j++) begin
         win_in[j] = win_ff[j];
      end
      if (cmd.append) begin
         win_in[cnt_ff[1:0]] = req_input_byte;
      end else if (cmd.drop_seq || cmd.drop_one) begin
         for (int j = 0; j < WIN_DEPTH; j++) begin
            src = (CNT_W+1)'(j) + {1'b0, k_drop};
            if (src < (CNT_W+1)'(WIN_DEPTH)) begin
               win_in[j] = win_ff[src[1:0]];
            end
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.append) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.drop_seq || cmd.drop_one) begin
         cnt_in = cnt_ff - k_drop;
      end
   end

   always_comb begin
      unique case (cmd.sel)
         UNIT_POINT: unit_new = unit_point;
         UNIT_LOW:   unit_new = lo_ff;
         UNIT_REPL:  unit_new = REPL_UNIT;
         UNIT_TERM:  unit_new = TERM_UNIT;
         default:    unit_new = REPL_UNIT;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < WIN_DEPTH; j++) begin
         win_ff[j] <= win_in[j];
      end
      if (cmd.emit) begin
         hold_unit_ff <= unit_new;
         hold_eos_ff  <= (cmd.sel == UNIT_TERM);
      end
      if (cmd.emit && (cmd.sel == UNIT_POINT)) begin
         lo_ff <= lo_point;
      end
      if (push) begin
         rsp_unit_ff <= hold_unit_ff;
         rsp_eos_ff  <= hold_eos_ff;
         rsp_eor_ff  <= cmd.flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.emit) begin
            hold_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            hold_valid_ff <= 1'b0;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_code_unit     = rsp_unit_ff;
   assign rsp_end_of_run    = rsp_eor_ff;
   assign rsp_end_of_string = rsp_eos_ff;

   `U8U16_ASSERT(a_append_room, clock, reset, cmd.append |-> (cnt_ff < CNT_W'(WIN_DEPTH)), "window overflow on append")
   `U8U16_ASSERT_NEVER(a_drop_bound, clock, reset, (cmd.drop_seq || cmd.drop_one) && (k_drop > cnt_ff), "drop beyond held bytes")
   `U8U16_ASSERT(a_push_free, clock, reset, push |-> out_free, "output beat overwritten")
   `U8U16_ASSERT(a_eos_closes_run, clock, reset, (rsp_valid_ff && rsp_eos_ff) |-> rsp_eor_ff, "terminator not last of run")

endmodule

### dv/utf8_to_utf16_transcoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_tb
// Drives UTF-8 strings into the transcoder and checks every UTF-16 unit.
// A directed set covers code point extremes, malformed forms and strings that
// end in the middle of a sequence. Random text follows, mostly well-formed with
// some damage; random idling on both sides or none; one long output stall.
// A built-in decoder with its own byte window predicts each beat's units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_tb;

   import u8u16_pkg::*;

   // Any slow but correct run finishes far below this.
   localparam int CYCLE_LIMIT        = 1000000;
   // Trailing quiet time after the last unit; covers the longest drain.
   localparam int DRAIN_CYCLES       = 16;
   // One byte never yields more units than this.
   localparam int MAX_UNITS_PER_BYTE = 5;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        end_of_run;
      logic        end_of_string;
   } utf16_beat_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_input_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_code_unit;
   logic        rsp_end_of_run;
   logic        rsp_end_of_string;

   // Units still owed by the block, oldest first.
   utf16_beat_type units_due[$];
   // Units produced by the byte being decoded right now.
   utf16_beat_type byte_units[$];
   // Decoder window: held bytes, lead first.
   logic [7:0]  win_bytes [WIN_DEPTH];
   int          win_fill;
   // Scratch string built by the text generator.
   logic [7:0]  text_bytes[$];

   int mismatch_count;
   int cycle_count;
   bit tx_idle_en;
   bit rx_idle_en;
   int hold_request;

   utf8_to_utf16_transcoder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_input_byte    (req_input_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_end_of_run    (rsp_end_of_run),
      .rsp_end_of_string (rsp_end_of_string)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // UTF-8 decoder used for prediction
   // -------------------------------------------------------------------------

   function automatic void add_unit(logic [15:0] unit, logic eos);
      utf16_beat_type b;
      b.code_unit     = unit;
      b.end_of_run    = 1'b0;
      b.end_of_string = eos;
      if (byte_units.size() < MAX_UNITS_PER_BYTE) byte_units = {byte_units, b};
   endfunction

   // One unit for a BMP point; a high and a low surrogate for a supplementary one.
   function automatic void add_code_point(logic [20:0] cp);
      logic [20:0] offset;
      if (cp[20:16] == 5'd0) begin
         add_unit(cp[15:0], 1'b0);
      end else begin
         offset = cp - SUPP_BASE;
         add_unit(HI_SURR | {6'd0, offset[19:10]}, 1'b0);
         add_unit(LO_SURR | {6'd0, offset[9:0]}, 1'b0);
      end
   endfunction

   function automatic void drop_lead(int k);
      int j;
      if (k >= win_fill) begin
         win_fill = 0;
      end else begin
         for (j = 0; j < win_fill - k; j++) win_bytes[j] = win_bytes[j + k];
         win_fill = win_fill - k;
      end
   endfunction

   // Decode every sequence whose bytes are all in the window.
   function automatic void decode_window();
      logic [7:0]  lead;
      logic [7:0]  c;
      logic [20:0] cp;
      logic [20:0] min_cp;
      int          need;
      int          i;
      bit          ok;
      while (win_fill > 0) begin
         lead   = win_bytes[0];
         need   = 1;
         cp     = {5'd0, REPL_UNIT};
         min_cp = '0;
         ok     = 1'b1;
         if (lead[7] == 1'b0) begin
            cp = {13'd0, lead};
         end else if (lead[7:5] == 3'b110) begin
            cp = {16'd0, lead[4:0]}; min_cp = MIN_TWO; need = 2;
         end else if (lead[7:4] == 4'b1110) begin
            cp = {17'd0, lead[3:0]}; min_cp = MIN_THREE; need = 3;
         end else if (lead[7:3] == 5'b11110) begin
            cp = {18'd0, lead[2:0]}; min_cp = SUPP_BASE; need = 4;
         end else begin
            // continuation byte or 0xF8-0xFF in lead position
            ok = 1'b0;
         end
         if (win_fill < need) break;
         for (i = 1; i < need; i++) begin
            c = win_bytes[i];
            if (c[7:6] != 2'b10) begin
               ok = 1'b0;
               break;
            end
            cp = (cp << 6) | {15'd0, c[5:0]};
         end
         if (!ok || cp < min_cp || cp > MAX_CP || (cp >= SURR_FIRST && cp <= SURR_LAST))
            cp = {5'd0, REPL_UNIT};
         add_code_point(cp);
         // a bad continuation stays in the window and is read again as a lead
         drop_lead(i);
      end
   endfunction

   // Work out the units one accepted byte causes and queue them.
   function automatic void predict_beat(logic [7:0] data, logic is_last);
      utf16_beat_type tail;
      byte_units.delete();
      if (win_fill >= WIN_DEPTH) win_fill = 0;
      win_bytes[win_fill] = data;
      win_fill++;
      decode_window();
      if (is_last) begin
         // string cut short: the lead gives a replacement, the rest re-read
         forever begin
            decode_window();
            if (win_fill == 0) break;
            add_unit(REPL_UNIT, 1'b0);
            drop_lead(1);
         end
         add_unit(TERM_UNIT, 1'b1);
         win_fill = 0;
      end
      if (byte_units.size() > 0) begin
         tail = byte_units[byte_units.size() - 1];
         tail.end_of_run = 1'b1;
         byte_units[byte_units.size() - 1] = tail;
      end
      units_due = {units_due, byte_units};
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Mostly no gap, some short ones, a few long ones.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one byte from the falling edge and hold it until the block takes it.
   task automatic send_beat(input logic [7:0] data, input logic is_last);
      int gap;
      gap = tx_idle_en ? gap_len() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_input_byte = data;
      req_last_byte  = is_last;
      req_valid      = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_beat(data, is_last);
   endtask

   // Add one byte at the end of the scratch string.
   function automatic void append_byte(logic [7:0] v);
      text_bytes = {text_bytes, v};
   endfunction

   function automatic void append_encoded(logic [20:0] cp, int len);
      case (len)
         1: append_byte({1'b0, cp[6:0]});
         2: begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
         end
         3: begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
         default: begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // Random code point that fits the shortest form of the given length.
   function automatic logic [20:0] point_for_len(int len);
      case (len)
         1:       return 21'($urandom_range(0, 'h7F));
         2:       return 21'($urandom_range('h80, 'h7FF));
         3:       return 21'($urandom_range('h800, 'hFFFF));
         default: return 21'($urandom_range('h10000, 'h10FFFF));
      endcase
   endfunction

   // Append one character: mostly well-formed, the rest damaged or noise.
   function automatic void append_random_char();
      int          r;
      int          len;
      int          k;
      logic [7:0]  b;
      logic [20:0] cp;
      r   = $urandom_range(0, 99);
      len = $urandom_range(2, 4);
      if (r < 25) begin
         append_encoded(point_for_len(1), 1);
      end else if (r < 45) begin
         append_encoded(point_for_len(2), 2);
      end else if (r < 65) begin
         append_encoded(point_for_len(3), 3);
      end else if (r < 78) begin
         append_encoded(point_for_len(4), 4);
      end else if (r < 81) begin
         // stray continuation or an impossible lead
         b = $urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                                  : 8'($urandom_range('hF8, 'hFF));
         append_byte(b);
      end else if (r < 84) begin
         // overlong: a point that fits a shorter form
         append_encoded(point_for_len(len - 1), len);
      end else if (r < 86) begin
         append_encoded(21'($urandom_range('hD800, 'hDFFF)), 3);
      end else if (r < 88) begin
         append_encoded(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      end else if (r < 93) begin
         // truncated: drop one or more trailing continuations
         append_encoded(point_for_len(len), len);
         repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
      end else if (r < 97) begin
         // replace one continuation with a byte that cannot continue
         cp = point_for_len(len);
         append_encoded(cp, len);
         k = $urandom_range(1, len - 1);
         b = 8'($urandom_range(0, 255));
         if (b[7:6] == 2'b10) b[6] = 1'b1;
         text_bytes[text_bytes.size() - len + k] = b;
      end else begin
         append_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   // Send whole random strings until about the requested number of bytes.
   task automatic send_random_text(input int beats);
      int sent;
      int chars;
      int r;
      sent = 0;
      while (sent < beats) begin
         text_bytes.delete();
         r = $urandom_range(0, 99);
         chars = (r < 70) ? $urandom_range(1, 6) :
                 (r < 95) ? $urandom_range(7, 20) : $urandom_range(40, 60);
         repeat (chars) append_random_char();
         foreach (text_bytes[i]) send_beat(text_bytes[i], i == text_bytes.size() - 1);
         sent += text_bytes.size();
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // ASCII extremes, shortest and longest well-formed sequences, max point.
   task automatic test_valid_forms();
      send_beat(8'h00, 1'b0);
      send_beat(8'h7F, 1'b0);
      // U+0080: lead only fills the window, no unit yet
      send_beat(8'hC2, 1'b0);
      send_beat(8'h80, 1'b0);
      // U+10FFFF as a surrogate pair, closing the string
      send_beat(8'hF4, 1'b0);
      send_beat(8'h8F, 1'b0);
      send_beat(8'hBF, 1'b0);
      send_beat(8'hBF, 1'b1);
   endtask

   // Bad lead, overlong, encoded surrogate, above the last code point.
   task automatic test_invalid_forms();
      send_beat(8'hFF, 1'b0);
      send_beat(8'hC0, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'hED, 1'b0);
      send_beat(8'hA0, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'hF4, 1'b0);
      send_beat(8'h90, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'h80, 1'b1);
   endtask

   // Four-byte lead followed by ASCII: one replacement, then each byte again.
   task automatic test_bad_continuation();
      send_beat(8'hF0, 1'b0);
      send_beat(8'h41, 1'b0);
      send_beat(8'h42, 1'b0);
      send_beat(8'h43, 1'b0);
   endtask

   // String ends inside a sequence: the last byte drains the whole window.
   task automatic test_truncated_end();
      send_beat(8'hF0, 1'b0);
      send_beat(8'hF0, 1'b0);
      send_beat(8'h90, 1'b0);
      send_beat(8'h80, 1'b1);
   endtask

   task automatic test_random_text();
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      send_random_text(170);
   endtask

   // No idling on either side: full rate.
   task automatic test_back_to_back();
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      send_random_text(120);
   endtask

   // Receiver holds off while bytes keep coming, so the input must stall.
   task automatic test_output_stall();
      tx_idle_en   = 1'b0;
      rx_idle_en   = 1'b1;
      hold_request = 300;
      send_random_text(40);
      tx_idle_en   = 1'b1;
      send_random_text(90);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: random stalls, plus any long hold-off a test asks for
   // -------------------------------------------------------------------------
   initial begin : rsp_drain
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 3) == 0) begin
            stall_left = gap_len();
         end
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Checker: compare each delivered unit with the oldest one owed
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : unit_checker
      utf16_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (units_due.size() == 0) begin
            $error("unexpected unit %h", rsp_code_unit);
            mismatch_count++;
         end else begin
            want = units_due.pop_front();
            if (rsp_code_unit !== want.code_unit) begin
               $error("code_unit: expected %h, got %h", want.code_unit, rsp_code_unit);
               mismatch_count++;
            end
            if (rsp_end_of_run !== want.end_of_run) begin
               $error("end_of_run: expected %b, got %b", want.end_of_run, rsp_end_of_run);
               mismatch_count++;
            end
            if (rsp_end_of_string !== want.end_of_string) begin
               $error("end_of_string: expected %b, got %b",
                      want.end_of_string, rsp_end_of_string);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("utf8_to_utf16_transcoder_tb failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_input_byte = '0;
      req_last_byte  = 1'b0;
      tx_idle_en     = 1'b1;
      rx_idle_en     = 1'b1;
      hold_request   = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      win_fill       = 0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_valid_forms();
      test_invalid_forms();
      test_bad_continuation();
      test_truncated_end();
      test_random_text();
      test_back_to_back();
      test_output_stall();

      // drop valid, wait for every owed unit, then watch for strays
      @(negedge clock);
      req_valid = 1'b0;
      while (units_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("utf8_to_utf16_transcoder_tb passed");
      end else begin
         $display("utf8_to_utf16_transcoder_tb failed");
      end
      $finish;
   end

endmodule
